### sv/trcf_pkg.sv
// trcf_pkg: shared types, constants and helper functions of the record check filter
// used by every module of temp_record_check_filter; no dependencies
`timescale 1ns / 1ps

package trcf_pkg;

  // window of converted readings
  localparam int WINDOW_LEN = 8;
  localparam int WIN_IW     = $clog2(WINDOW_LEN);

  // field widths
  localparam int DATA_W = 8;
  localparam int VAL_W  = 12;
  localparam int STAT_W = 2;

  // scratchpad record: bytes 0 to 7 under the crc, byte 8 holds the crc
  localparam int             REC_LAST = 8;
  localparam int             BCNT_W   = 4;
  localparam logic [DATA_W-1:0] CRC_POLY = 8'h8C;

  // largest magnitude of a converted reading
  localparam int MAX_TENTHS = 1279;

  // trimmed mean arithmetic
  localparam int SUM_W   = $clog2(WINDOW_LEN * MAX_TENTHS + 1) + 1;
  localparam int DIV     = WINDOW_LEN - 2;
  localparam int MAG_W   = $clog2(DIV * MAX_TENTHS + 1);
  localparam int DIV_SH  = MAG_W + $clog2(DIV) + 1;
  localparam int RECIP_W = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam int PROD_W  = MAG_W + RECIP_W;

  // job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_IW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_CRC    = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // one job handed from front to back
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } job_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_MUL,
    BK_FIN,
    BK_OUT
  } bk_state_t;

  // sixteenths of a degree to tenths
  function automatic logic [3:0] frac_tenths(input logic [3:0] n);
    logic [3:0] t;
    case (n)
      4'd0:  t = 4'd0;
      4'd1:  t = 4'd1;
      4'd2:  t = 4'd1;
      4'd3:  t = 4'd2;
      4'd4:  t = 4'd3;
      4'd5:  t = 4'd3;
      4'd6:  t = 4'd4;
      4'd7:  t = 4'd4;
      4'd8:  t = 4'd5;
      4'd9:  t = 4'd6;
      4'd10: t = 4'd6;
      4'd11: t = 4'd7;
      4'd12: t = 4'd8;
      4'd13: t = 4'd8;
      4'd14: t = 4'd9;
      default: t = 4'd9;
    endcase
    return t;
  endfunction

endpackage

### sv/trcf_front.sv
// trcf_front: takes scratchpad beats, runs the crc and latches the temperature bytes
// depends on trcf_pkg; pushes one job per finished record or absent-device beat
`timescale 1ns / 1ps

module trcf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [trcf_pkg::DATA_W-1:0]  in_tdata,
  input  logic                         in_tuser,
  input  trcf_pkg::q_stat_t            q_stat,
  output logic                         push,
  output trcf_pkg::job_t               job
);

  logic [trcf_pkg::BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [trcf_pkg::DATA_W-1:0] crc_r, crc_nxt;
  logic [trcf_pkg::DATA_W-1:0] lo_r, lo_nxt;
  logic [trcf_pkg::DATA_W-1:0] hi_r, hi_nxt;
  logic                        acc;
  logic                        last_byte;

  // reflected crc-8, one bit per step
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ trcf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign last_byte = (bcnt_r == trcf_pkg::BCNT_W'(trcf_pkg::REC_LAST));

  always_comb begin
    bcnt_nxt   = bcnt_r;
    crc_nxt    = crc_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    push       = 1'b0;
    job.status = trcf_pkg::ST_OK;
    job.lo     = lo_r;
    job.hi     = hi_r;
    if (acc) begin
      if (in_tuser) begin
        bcnt_nxt   = '0;
        crc_nxt    = '0;
        push       = 1'b1;
        job.status = trcf_pkg::ST_ABSENT;
      end else if (last_byte) begin
        bcnt_nxt   = '0;
        crc_nxt    = '0;
        push       = 1'b1;
        job.status = (crc_r == in_tdata) ? trcf_pkg::ST_OK : trcf_pkg::ST_CRC;
      end else begin
        if (bcnt_r == trcf_pkg::BCNT_W'(0)) lo_nxt = in_tdata;
        if (bcnt_r == trcf_pkg::BCNT_W'(1)) hi_nxt = in_tdata;
        crc_nxt  = crc8_step(crc_r, in_tdata);
        bcnt_nxt = bcnt_r + trcf_pkg::BCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      crc_r  <= '0;
      lo_r   <= '0;
      hi_r   <= '0;
    end else begin
      bcnt_r <= bcnt_nxt;
      crc_r  <= crc_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

### sv/trcf_queue.sv
// trcf_queue: short job queue between the front and the back
// depends on trcf_pkg for the job type and depth
`timescale 1ns / 1ps

module trcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  trcf_pkg::job_t    push_job,
  input  logic              pop,
  output trcf_pkg::job_t    head,
  output trcf_pkg::q_stat_t q_stat
);

  trcf_pkg::job_t            mem_r [trcf_pkg::Q_DEPTH];
  logic [trcf_pkg::Q_IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [trcf_pkg::Q_IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [trcf_pkg::Q_CW-1:0] cnt_r, cnt_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign q_stat.full  = (cnt_r == trcf_pkg::Q_CW'(trcf_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == trcf_pkg::Q_IW'(trcf_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + trcf_pkg::Q_IW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == trcf_pkg::Q_IW'(trcf_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + trcf_pkg::Q_IW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + trcf_pkg::Q_CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - trcf_pkg::Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

### sv/trcf_back.sv
// trcf_back: converts a good record, updates the window and forms the trimmed mean
// depends on trcf_pkg; holds the result register that drives the output channel
`timescale 1ns / 1ps

module trcf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  trcf_pkg::job_t                     head,
  input  trcf_pkg::q_stat_t                  q_stat,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [2*trcf_pkg::VAL_W-1:0]       out_tdata,
  output logic [trcf_pkg::STAT_W-1:0]        out_tuser
);

  trcf_pkg::bk_state_t              state_r, state_nxt;
  logic signed [trcf_pkg::VAL_W-1:0] win_r [trcf_pkg::WINDOW_LEN];
  logic [trcf_pkg::WIN_IW-1:0]      wp_r, wp_nxt;
  logic [trcf_pkg::WIN_IW-1:0]      idx_r, idx_nxt;
  logic signed [trcf_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic signed [trcf_pkg::VAL_W-1:0] mx_r, mx_nxt;
  logic signed [trcf_pkg::VAL_W-1:0] mn_r, mn_nxt;
  logic [trcf_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic                             sgn_r, sgn_nxt;
  trcf_pkg::status_t                stat_r, stat_nxt;
  logic signed [trcf_pkg::VAL_W-1:0] rdg_r, rdg_nxt;
  logic signed [trcf_pkg::VAL_W-1:0] filt_r, filt_nxt;
  logic                             win_we;

  // conversion of the latched temperature bytes
  logic [15:0]                      raw;
  logic [15:0]                      mag16;
  logic [6:0]                       int7;
  logic [trcf_pkg::VAL_W-2:0]       v11;
  logic signed [trcf_pkg::VAL_W-1:0] conv;

  // walk and trimmed mean
  logic signed [trcf_pkg::VAL_W-1:0] w;
  logic signed [trcf_pkg::SUM_W-1:0] w_ext, mx_ext, mn_ext, trimmed, tabs;
  logic [trcf_pkg::MAG_W-1:0]       tmag;
  logic [trcf_pkg::VAL_W-1:0]       q;

  assign raw   = {head.hi, head.lo};
  assign mag16 = raw[15] ? (~raw + 16'd1) : raw;
  assign int7  = mag16[10:4];
  assign v11   = (trcf_pkg::VAL_W-1)'({int7, 3'b000}) + (trcf_pkg::VAL_W-1)'({int7, 1'b0})
               + (trcf_pkg::VAL_W-1)'(trcf_pkg::frac_tenths(mag16[3:0]));
  assign conv  = raw[15] ? -$signed({1'b0, v11}) : $signed({1'b0, v11});

  assign w       = win_r[idx_r];
  assign w_ext   = {{(trcf_pkg::SUM_W-trcf_pkg::VAL_W){w[trcf_pkg::VAL_W-1]}}, w};
  assign mx_ext  = {{(trcf_pkg::SUM_W-trcf_pkg::VAL_W){mx_r[trcf_pkg::VAL_W-1]}}, mx_r};
  assign mn_ext  = {{(trcf_pkg::SUM_W-trcf_pkg::VAL_W){mn_r[trcf_pkg::VAL_W-1]}}, mn_r};
  assign trimmed = sum_r - mx_ext - mn_ext;
  assign tabs    = trimmed[trcf_pkg::SUM_W-1] ? -trimmed : trimmed;
  assign tmag    = tabs[trcf_pkg::MAG_W-1:0];
  assign q       = prod_r[trcf_pkg::DIV_SH +: trcf_pkg::VAL_W];

  assign out_tvalid = (state_r == trcf_pkg::BK_OUT);
  assign out_tdata  = {filt_r, rdg_r};
  assign out_tuser  = stat_r;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    mx_nxt    = mx_r;
    mn_nxt    = mn_r;
    prod_nxt  = prod_r;
    sgn_nxt   = sgn_r;
    stat_nxt  = stat_r;
    rdg_nxt   = rdg_r;
    filt_nxt  = filt_r;
    win_we    = 1'b0;
    pop       = 1'b0;
    unique case (state_r)
      trcf_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          stat_nxt = head.status;
          if (head.status == trcf_pkg::ST_OK) begin
            win_we    = 1'b1;
            rdg_nxt   = conv;
            wp_nxt    = (wp_r == trcf_pkg::WIN_IW'(trcf_pkg::WINDOW_LEN - 1)) ? '0 :
                        wp_r + trcf_pkg::WIN_IW'(1);
            idx_nxt   = '0;
            state_nxt = trcf_pkg::BK_WALK;
          end else begin
            rdg_nxt   = '0;
            filt_nxt  = '0;
            state_nxt = trcf_pkg::BK_OUT;
          end
        end
      end
      trcf_pkg::BK_WALK: begin
        if (idx_r == '0) begin
          sum_nxt = w_ext;
          mx_nxt  = w;
          mn_nxt  = w;
        end else begin
          sum_nxt = sum_r + w_ext;
          if (w > mx_r) mx_nxt = w;
          if (w < mn_r) mn_nxt = w;
        end
        if (idx_r == trcf_pkg::WIN_IW'(trcf_pkg::WINDOW_LEN - 1)) begin
          state_nxt = trcf_pkg::BK_MUL;
        end else begin
          idx_nxt = idx_r + trcf_pkg::WIN_IW'(1);
        end
      end
      trcf_pkg::BK_MUL: begin
        // divide by the constant through its reciprocal
        prod_nxt  = trcf_pkg::PROD_W'(tmag) * trcf_pkg::PROD_W'(trcf_pkg::RECIP);
        sgn_nxt   = trimmed[trcf_pkg::SUM_W-1];
        state_nxt = trcf_pkg::BK_FIN;
      end
      trcf_pkg::BK_FIN: begin
        filt_nxt  = sgn_r ? -$signed(q) : $signed(q);
        state_nxt = trcf_pkg::BK_OUT;
      end
      trcf_pkg::BK_OUT: begin
        if (out_tready) state_nxt = trcf_pkg::BK_IDLE;
      end
      default: state_nxt = trcf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trcf_pkg::BK_IDLE;
      wp_r    <= '0;
      for (int i = 0; i < trcf_pkg::WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (win_we) win_r[wp_r] <= conv;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    sum_r  <= sum_nxt;
    mx_r   <= mx_nxt;
    mn_r   <= mn_nxt;
    prod_r <= prod_nxt;
    sgn_r  <= sgn_nxt;
    stat_r <= stat_nxt;
    rdg_r  <= rdg_nxt;
    filt_r <= filt_nxt;
  end

endmodule

### sv/temp_record_check_filter.sv
// temp_record_check_filter: top level of the sensor record check and trimmed mean filter
// depends on trcf_pkg, trcf_front, trcf_queue and trcf_back
`timescale 1ns / 1ps

// The block takes a temperature sensor's nine scratchpad bytes as input beats
// (in_tuser low) or an absent-device beat (in_tuser high). Bytes 0 to 7 run
// through the reflected crc-8 (polynomial 0x31) and byte 8 is checked against
// it. Each record's last byte, and each absent-device beat, gives exactly one
// result beat: status 0 with the reading and the window's trimmed mean in
// tenths of a degree, status 1 on a crc mismatch or status 2 for an absent
// device, both values zero on error. Bytes are taken one per cycle while the
// two-entry job queue has room. For a good record the back end converts the
// reading and writes the window, walks the window for sum, max and min, does
// the reciprocal multiply and applies the sign; an error result is ready in
// the cycle after pickup. The back end handles one record at a time and holds
// its result in the output register until it is taken. The window resets to
// all zero, with no clearing pass.

module temp_record_check_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [trcf_pkg::DATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] cmd (absent device)
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [2*trcf_pkg::VAL_W-1:0]   out_tdata,  // [11:0] reading_tenths, [23:12] filtered_tenths
  output logic [trcf_pkg::STAT_W-1:0]    out_tuser   // [1:0] status
);

  trcf_pkg::q_stat_t q_stat;
  trcf_pkg::job_t    push_job;
  trcf_pkg::job_t    head;
  logic              push;
  logic              pop;

  // front: crc, byte count and temperature byte capture
  trcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // jobs wait here so the front waits on the window walk only when the queue is full
  trcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: conversion, window update, trimmed mean, result register
  trcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sv/trcf_checker.sv
// trcf_checker: port-level assertions for temp_record_check_filter
// depends on trcf_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module trcf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [2*trcf_pkg::VAL_W-1:0]  out_tdata,
  input logic [trcf_pkg::STAT_W-1:0]   out_tuser
);

  logic signed [trcf_pkg::VAL_W-1:0] rdg;
  logic signed [trcf_pkg::VAL_W-1:0] filt;

  assign rdg  = out_tdata[trcf_pkg::VAL_W-1:0];
  assign filt = out_tdata[2*trcf_pkg::VAL_W-1:trcf_pkg::VAL_W];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // error results carry zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != trcf_pkg::ST_OK |-> out_tdata == '0)
    else $error("error result with nonzero values");

  // good results stay within the converted range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == trcf_pkg::ST_OK |->
      rdg <= trcf_pkg::VAL_W'(trcf_pkg::MAX_TENTHS) &&
      rdg >= -trcf_pkg::VAL_W'(trcf_pkg::MAX_TENTHS) &&
      filt <= trcf_pkg::VAL_W'(trcf_pkg::MAX_TENTHS) &&
      filt >= -trcf_pkg::VAL_W'(trcf_pkg::MAX_TENTHS))
    else $error("result value out of range");

  // reset drops any pending result
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // empty queue after reset, so the input side is open
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind temp_record_check_filter trcf_checker u_trcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
